/* design/jkv_pkg.sv */
// Shared constants, types and helpers of the JSON key/value extractor.
`default_nettype none

package jkv_pkg;

    // Key storage and configuration port
    localparam int MAX_KEY_LENGTH = 16;
    localparam int KEY_POS_W      = 5;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 64;

    // Result queue depth (power of two, at least 2)
    localparam int FIFO_DEPTH     = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_MODE = 2'd3;

    // Value modes
    localparam logic [1:0] MODE_STRING  = 2'd0;
    localparam logic [1:0] MODE_INTEGER = 2'd1;
    localparam logic [1:0] MODE_BOOLEAN = 2'd2;

    // Result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // Saturation limits as magnitudes
    localparam logic [63:0] INT_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT_NEG_LIMIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [63:0]          key_low;
        logic [63:0]          key_high;
        logic [KEY_POS_W-1:0] key_length;
        logic [1:0]           value_mode;
    } cfg_t;

    typedef struct packed {
        logic               result_kind;
        logic [7:0]         value_byte;
        logic               key_found;
        logic signed [63:0] integer_value;
        logic               boolean_value;
    } result_t;

    // Up to two results produced by one text byte, packed from slot0
    typedef struct packed {
        logic [1:0] count;
        result_t    slot0;
        result_t    slot1;
    } push_t;

    // Characters of the literal "true"
    function automatic logic [7:0] true_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = 8'h74;
            2'd1:    ch = 8'h72;
            2'd2:    ch = 8'h75;
            default: ch = 8'h65;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* design/jkv_channels.sv */
// Valid/ready channel interfaces for text bytes and results.
`default_nettype none

interface jkv_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_document;

    modport source (output valid, output text_byte, output end_of_document, input ready);
    modport sink   (input valid, input text_byte, input end_of_document, output ready);
endinterface

interface jkv_result_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [7:0]         value_byte;
    logic               key_found;
    logic signed [63:0] integer_value;
    logic               boolean_value;

    modport source (output valid, output result_kind, output value_byte, output key_found,
                    output integer_value, output boolean_value, input ready);
    modport sink   (input valid, input result_kind, input value_byte, input key_found,
                    input integer_value, input boolean_value, output ready);
endinterface

`default_nettype wire

/* design/json_key_value_extractor_top.sv */
// Top level of the JSON key/value extractor.
//
// in_text takes one document byte per request with an end_of_document flag on
// the last byte. out_result gives string value bytes (result_kind 0) and one
// summary per document (result_kind 1) with key_found, the saturated integer
// and the "true" test. The user must write the key, its length and the value
// mode on the cfg_wr_en / cfg_index / cfg_data port only while no text is
// in flight; the block itself does not enforce this. A byte passes the input
// register, is scanned, and its results are written into the result queue,
// whose head drives out_result. Throughput: one byte per cycle while each
// byte yields at most one result and the queue has room; a byte that yields
// both a string byte and its summary pushes two results. The scanner runs
// only while the result queue has two free entries, so a stalled receiver
// fills the queue and then holds ready low on in_text; nothing is dropped.
// Reset clears the scan state, the queue and the configuration registers;
// the scan restarts itself after every end_of_document byte.
`default_nettype none

module json_key_value_extractor_top
#(
    parameter int FIFO_DEPTH = jkv_pkg::FIFO_DEPTH
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    jkv_text_if.sink                              in_text,
    jkv_result_if.source                          out_result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [jkv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [jkv_pkg::CFG_DATA_W-1:0]   cfg_data
);

    jkv_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_eod_reg;
    logic             room;
    logic             fire;
    logic             head_valid;
    logic             pop;
    jkv_pkg::push_t   push;
    jkv_pkg::result_t head;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                jkv_pkg::REG_KEY_LOW:    cfg_reg.key_low    <= cfg_data;
                jkv_pkg::REG_KEY_HIGH:   cfg_reg.key_high   <= cfg_data;
                jkv_pkg::REG_KEY_LENGTH: cfg_reg.key_length <= cfg_data[jkv_pkg::KEY_POS_W-1:0];
                jkv_pkg::REG_VALUE_MODE: cfg_reg.value_mode <= cfg_data[1:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    // Input register: refills whenever its byte moves on to the scanner
    assign fire          = in_valid_reg && room;
    assign in_text.ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_text.ready)
            in_valid_reg <= in_text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_text.valid && in_text.ready)
        begin
            in_byte_reg <= in_text.text_byte;
            in_eod_reg  <= in_text.end_of_document;
        end
    end

    jkv_scan u_scan
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .fire            (fire),
        .text_byte       (in_byte_reg),
        .end_of_document (in_eod_reg),
        .push            (push)
    );

    jkv_result_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .room       (room)
    );

    // Output channel
    assign pop                      = head_valid && out_result.ready;
    assign out_result.valid         = head_valid;
    assign out_result.result_kind   = head.result_kind;
    assign out_result.value_byte    = head.value_byte;
    assign out_result.key_found     = head.key_found;
    assign out_result.integer_value = head.integer_value;
    assign out_result.boolean_value = head.boolean_value;

endmodule

`default_nettype wire

/* design/jkv_scan.sv */
// Byte scanner: key match, value extraction and per-document summary.
`default_nettype none

module jkv_scan
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire jkv_pkg::cfg_t cfg,
    input  wire logic          fire,
    input  wire logic [7:0]    text_byte,
    input  wire logic          end_of_document,
    output jkv_pkg::push_t     push
);

    typedef enum logic [3:0] {
        PH_SEARCH,
        PH_KEY,
        PH_AFTER_KEY,
        PH_BEFORE_VALUE,
        PH_STRING,
        PH_DIGITS,
        PH_BOOL,
        PH_VALUE_DONE,
        PH_STOPPED
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    phase_t                          phase_reg, phase_next, scan_phase;
    logic [jkv_pkg::KEY_POS_W-1:0]   key_pos_reg, key_pos_next, scan_key_pos;
    logic                            mismatch_reg, mismatch_next, scan_mismatch;
    logic                            escape_reg, escape_next, scan_escape;
    logic [63:0]                     mag_reg, mag_next, scan_mag;
    logic                            neg_reg, neg_next, scan_neg;
    logic                            ovf_reg, ovf_next, scan_ovf;
    logic [2:0]                      true_cnt_reg, true_cnt_next, scan_true_cnt;
    logic                            emit;

    logic [127:0] key_all;
    logic [7:0]   key_char;
    logic         is_space, is_digit, key_len_ok, key_pos_room;
    logic [3:0]   digit;
    logic [67:0]  digit_sum, digit_limit;
    logic         digit_ovf;
    logic         true_hit;
    logic [2:0]   true_cnt_inc;
    logic         found;
    logic [63:0]  final_int;
    jkv_pkg::result_t byte_res, final_res;

    // Byte classes and key character at the current match position
    assign key_all      = {cfg.key_high, cfg.key_low};
    assign key_char     = key_all[{key_pos_reg[3:0], 3'b000} +: 8];
    assign is_space     = (text_byte == 8'd32) || (text_byte >= 8'd9 && text_byte <= 8'd13);
    assign is_digit     = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    assign digit        = 4'(text_byte - CH_ZERO);
    assign key_len_ok   = cfg.key_length <= jkv_pkg::KEY_POS_W'(jkv_pkg::MAX_KEY_LENGTH);
    assign key_pos_room = (key_pos_reg < cfg.key_length)
                       && (key_pos_reg < jkv_pkg::KEY_POS_W'(jkv_pkg::MAX_KEY_LENGTH));

    // Decimal accumulate: magnitude*10 + digit, checked against the signed limit
    assign digit_sum   = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + {64'd0, digit};
    assign digit_limit = {4'd0, (neg_reg ? jkv_pkg::INT_NEG_LIMIT : jkv_pkg::INT_POS_LIMIT)};
    assign digit_ovf   = digit_sum > digit_limit;

    // Literal "true" progress
    assign true_hit     = (true_cnt_reg < 3'd4)
                       && (text_byte == jkv_pkg::true_char(true_cnt_reg[1:0]));
    assign true_cnt_inc = true_cnt_reg + 3'd1;

    // Scan one byte
    always_comb
    begin
        scan_phase    = phase_reg;
        scan_key_pos  = key_pos_reg;
        scan_mismatch = mismatch_reg;
        scan_escape   = escape_reg;
        scan_mag      = mag_reg;
        scan_neg      = neg_reg;
        scan_ovf      = ovf_reg;
        scan_true_cnt = true_cnt_reg;
        emit          = 1'b0;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (text_byte == CH_NUL)
                begin
                    scan_phase = PH_STOPPED;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    scan_phase    = PH_KEY;
                    scan_key_pos  = '0;
                    scan_mismatch = 1'b0;
                end
            end
            PH_KEY:
            begin
                if (text_byte == CH_NUL)
                    scan_phase = PH_STOPPED;
                else if (text_byte == CH_QUOTE)
                    scan_phase = PH_AFTER_KEY;
                else if (key_pos_room && text_byte == key_char)
                    scan_key_pos = key_pos_reg + jkv_pkg::KEY_POS_W'(1);
                else
                    scan_mismatch = 1'b1;
            end
            PH_AFTER_KEY:
            begin
                if (is_space)
                begin
                    scan_phase = PH_AFTER_KEY;
                end
                else if (text_byte == CH_COLON && !mismatch_reg
                         && key_pos_reg == cfg.key_length && key_len_ok)
                begin
                    scan_phase = PH_BEFORE_VALUE;
                end
                // Not our key: rescan this byte as a search byte
                else if (text_byte == CH_NUL)
                begin
                    scan_phase = PH_STOPPED;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    scan_phase    = PH_KEY;
                    scan_key_pos  = '0;
                    scan_mismatch = 1'b0;
                end
                else
                begin
                    scan_phase = PH_SEARCH;
                end
            end
            PH_BEFORE_VALUE:
            begin
                if (!is_space)
                begin
                    case (cfg.value_mode)
                        jkv_pkg::MODE_STRING:
                        begin
                            scan_phase = (text_byte == CH_QUOTE) ? PH_STRING : PH_VALUE_DONE;
                        end
                        jkv_pkg::MODE_INTEGER:
                        begin
                            if (text_byte == CH_PLUS || text_byte == CH_MINUS)
                            begin
                                scan_neg   = (text_byte == CH_MINUS);
                                scan_phase = PH_DIGITS;
                            end
                            else if (is_digit)
                            begin
                                if (digit_ovf)
                                    scan_ovf = 1'b1;
                                else
                                    scan_mag = digit_sum[63:0];
                                scan_phase = PH_DIGITS;
                            end
                            else
                            begin
                                scan_phase = PH_VALUE_DONE;
                            end
                        end
                        jkv_pkg::MODE_BOOLEAN:
                        begin
                            if (true_hit)
                            begin
                                scan_true_cnt = true_cnt_inc;
                                scan_phase    = (true_cnt_inc == 3'd4) ? PH_VALUE_DONE : PH_BOOL;
                            end
                            else
                            begin
                                scan_phase = PH_VALUE_DONE;
                            end
                        end
                        default:
                        begin
                            scan_phase = PH_VALUE_DONE;
                        end
                    endcase
                end
            end
            PH_STRING:
            begin
                if (text_byte == CH_NUL)
                begin
                    scan_phase = PH_VALUE_DONE;
                end
                else if (escape_reg)
                begin
                    scan_escape = 1'b0;
                    emit        = 1'b1;
                end
                else if (text_byte == CH_QUOTE)
                begin
                    scan_phase = PH_VALUE_DONE;
                end
                else
                begin
                    scan_escape = (text_byte == CH_BSLSH);
                    emit        = 1'b1;
                end
            end
            PH_DIGITS:
            begin
                if (is_digit)
                begin
                    if (!ovf_reg)
                    begin
                        if (digit_ovf)
                            scan_ovf = 1'b1;
                        else
                            scan_mag = digit_sum[63:0];
                    end
                end
                else
                begin
                    scan_phase = PH_VALUE_DONE;
                end
            end
            PH_BOOL:
            begin
                if (true_hit)
                begin
                    scan_true_cnt = true_cnt_inc;
                    scan_phase    = (true_cnt_inc == 3'd4) ? PH_VALUE_DONE : PH_BOOL;
                end
                else
                begin
                    scan_phase = PH_VALUE_DONE;
                end
            end
            default:
            begin
                scan_phase = phase_reg;
            end
        endcase
    end

    // Document summary from the state after this byte
    always_comb
    begin
        found = (scan_phase >= PH_BEFORE_VALUE) && (scan_phase <= PH_VALUE_DONE);
        if (!found || cfg.value_mode != jkv_pkg::MODE_INTEGER)
            final_int = 64'd0;
        else if (scan_ovf)
            final_int = scan_neg ? jkv_pkg::INT_NEG_LIMIT : jkv_pkg::INT_POS_LIMIT;
        else
            final_int = scan_neg ? (64'd0 - scan_mag) : scan_mag;

        final_res.result_kind   = jkv_pkg::KIND_FINAL;
        final_res.value_byte    = 8'd0;
        final_res.key_found     = found;
        final_res.integer_value = final_int;
        final_res.boolean_value = found && (cfg.value_mode == jkv_pkg::MODE_BOOLEAN)
                               && (scan_true_cnt == 3'd4);

        byte_res.result_kind   = jkv_pkg::KIND_BYTE;
        byte_res.value_byte    = text_byte;
        byte_res.key_found     = 1'b0;
        byte_res.integer_value = 64'sd0;
        byte_res.boolean_value = 1'b0;

        push.count = fire ? ({1'b0, emit} + {1'b0, end_of_document}) : 2'd0;
        push.slot0 = emit ? byte_res : final_res;
        push.slot1 = final_res;
    end

    // Restart the scan after the last byte of a document
    always_comb
    begin
        if (end_of_document)
        begin
            phase_next    = PH_SEARCH;
            key_pos_next  = '0;
            mismatch_next = 1'b0;
            escape_next   = 1'b0;
            mag_next      = 64'd0;
            neg_next      = 1'b0;
            ovf_next      = 1'b0;
            true_cnt_next = 3'd0;
        end
        else
        begin
            phase_next    = scan_phase;
            key_pos_next  = scan_key_pos;
            mismatch_next = scan_mismatch;
            escape_next   = scan_escape;
            mag_next      = scan_mag;
            neg_next      = scan_neg;
            ovf_next      = scan_ovf;
            true_cnt_next = scan_true_cnt;
        end
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEARCH;
            key_pos_reg  <= '0;
            mismatch_reg <= 1'b0;
            escape_reg   <= 1'b0;
            mag_reg      <= 64'd0;
            neg_reg      <= 1'b0;
            ovf_reg      <= 1'b0;
            true_cnt_reg <= 3'd0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            key_pos_reg  <= key_pos_next;
            mismatch_reg <= mismatch_next;
            escape_reg   <= escape_next;
            mag_reg      <= mag_next;
            neg_reg      <= neg_next;
            ovf_reg      <= ovf_next;
            true_cnt_reg <= true_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* design/jkv_result_fifo.sv */
// Result queue taking up to two results per cycle and giving one.
`default_nettype none

module jkv_result_fifo
#(
    parameter int DEPTH = jkv_pkg::FIFO_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire jkv_pkg::push_t   push,
    input  wire logic             pop,
    output jkv_pkg::result_t      head,
    output logic                  head_valid,
    output logic                  room
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    jkv_pkg::result_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign head         = entries_reg[rd_ptr_reg];
    assign head_valid   = count_reg != '0;
    // Two free entries needed before the scanner may run
    assign room         = count_reg <= CNT_W'(DEPTH - 2);

    // Pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries_reg[wr_ptr_reg] <= push.slot0;
        if (push.count == 2'd2)
            entries_reg[wr_ptr_plus1] <= push.slot1;
    end

endmodule

`default_nettype wire

/* test/tb_json_key_value_extractor_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the JSON key/value extractor: random documents against a scan model.
module tb_json_key_value_extractor_top;

    localparam int CYCLE_LIMIT       = 1000000;
    localparam int SETTLE_CYCLES     = 8;
    localparam int RANDOM_TEXT_BYTES = 1900;
    localparam int DOCS_PER_SETTING  = 8;
    localparam int REPORT_LIMIT      = 10;

    // Mode with no extraction; the package names only the first three
    localparam logic [1:0] MODE_KEY_ONLY = 2'd3;

    // Characters the scanner reacts to, and those used to build documents
    localparam logic [7:0] CH_NUL         = 8'h00;
    localparam logic [7:0] CH_TAB         = 8'h09;
    localparam logic [7:0] CH_CR          = 8'h0D;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_QUOTE       = 8'h22;
    localparam logic [7:0] CH_PLUS        = 8'h2B;
    localparam logic [7:0] CH_COMMA       = 8'h2C;
    localparam logic [7:0] CH_MINUS       = 8'h2D;
    localparam logic [7:0] CH_DIGIT0      = 8'h30;
    localparam logic [7:0] CH_DIGIT9      = 8'h39;
    localparam logic [7:0] CH_COLON       = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH   = 8'h5C;
    localparam logic [7:0] CH_OPEN_BRACE  = 8'h7B;
    localparam logic [7:0] CH_CLOSE_BRACE = 8'h7D;
    localparam logic [31:0] TRUE_WORD     = "true";
    localparam logic [7:0] DIRECTED_KEY   = "k";

    typedef enum logic [3:0] {
        SCAN_SEARCH,
        SCAN_KEY,
        SCAN_AFTER_KEY,
        SCAN_BEFORE_VALUE,
        SCAN_STRING,
        SCAN_DIGITS,
        SCAN_BOOL,
        SCAN_VALUE_DONE,
        SCAN_STOPPED
    } scan_phase_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_document;
    } text_req_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_wr_en;
    logic [jkv_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [jkv_pkg::CFG_DATA_W-1:0]  cfg_data;

    jkv_text_if   in_text ();
    jkv_result_if out_result ();

    json_key_value_extractor_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_text    (in_text),
        .out_result (out_result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Scan model state and its copy of the registers
    jkv_pkg::cfg_t extractor_cfg;
    scan_phase_t   text_phase;
    logic [4:0]    key_pos;
    logic          key_miss;
    logic          escape_next;
    logic [63:0]   int_magnitude;
    logic          int_negative;
    logic          int_overflow;
    logic [2:0]    true_count;

    text_req_t         pending_text[$];
    jkv_pkg::result_t  expected_results[$];
    logic [7:0]        doc_text[$];
    int                text_bytes_queued;
    int                error_count = 0;
    int                cycle_count = 0;
    int                burst_left;
    int                gap_left;
    logic [31:0]       stall_bits;
    logic [4:0]        stall_pos;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_json_space(logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic logic [7:0] key_char(int idx);
        if (idx < 8)
            return extractor_cfg.key_low[8*idx +: 8];
        return extractor_cfg.key_high[8*(idx-8) +: 8];
    endfunction

    function automatic void clear_scan();
        text_phase    = SCAN_SEARCH;
        key_pos       = '0;
        key_miss      = 1'b0;
        escape_next   = 1'b0;
        int_magnitude = '0;
        int_negative  = 1'b0;
        int_overflow  = 1'b0;
        true_count    = '0;
    endfunction

    // Accumulate one digit; sticks at overflow once the limit would be passed
    function automatic void add_decimal_digit(logic [63:0] digit);
        logic [63:0] ceiling;
        ceiling = int_negative ? jkv_pkg::INT_NEG_LIMIT : jkv_pkg::INT_POS_LIMIT;
        if (!int_overflow)
        begin
            if (int_magnitude > (ceiling - digit) / 64'd10)
                int_overflow = 1'b1;
            else
                int_magnitude = int_magnitude * 64'd10 + digit;
        end
    endfunction

    function automatic void match_true_char(logic [7:0] ch);
        if (true_count < 4 && ch == TRUE_WORD[8*(3-true_count) +: 8])
        begin
            true_count++;
            text_phase = (true_count == 4) ? SCAN_VALUE_DONE : SCAN_BOOL;
        end
        else
            text_phase = SCAN_VALUE_DONE;
    endfunction

    function automatic void look_for_key_quote(logic [7:0] ch);
        if (ch == CH_NUL)
            text_phase = SCAN_STOPPED;
        else if (ch == CH_QUOTE)
        begin
            text_phase = SCAN_KEY;
            key_pos    = '0;
            key_miss   = 1'b0;
        end
    endfunction

    // Advance the scan by one byte; returns 1 when the byte is a string value byte
    function automatic bit scan_json_byte(logic [7:0] ch);
        bit give;
        give = 1'b0;
        case (text_phase)
            SCAN_SEARCH:
                look_for_key_quote(ch);
            SCAN_KEY:
                if (ch == CH_NUL)
                    text_phase = SCAN_STOPPED;
                else if (ch == CH_QUOTE)
                    text_phase = SCAN_AFTER_KEY;
                else if (key_pos < extractor_cfg.key_length &&
                         key_pos < jkv_pkg::MAX_KEY_LENGTH && ch == key_char(key_pos))
                    key_pos++;
                else
                    key_miss = 1'b1;
            SCAN_AFTER_KEY:
                if (!is_json_space(ch))
                begin
                    if (ch == CH_COLON && !key_miss && key_pos == extractor_cfg.key_length &&
                        extractor_cfg.key_length <= jkv_pkg::MAX_KEY_LENGTH)
                        text_phase = SCAN_BEFORE_VALUE;
                    else
                    begin
                        // not a key after all: the byte is scanned again from search
                        text_phase = SCAN_SEARCH;
                        look_for_key_quote(ch);
                    end
                end
            SCAN_BEFORE_VALUE:
                if (!is_json_space(ch))
                begin
                    case (extractor_cfg.value_mode)
                        jkv_pkg::MODE_STRING:
                            text_phase = (ch == CH_QUOTE) ? SCAN_STRING : SCAN_VALUE_DONE;
                        jkv_pkg::MODE_INTEGER:
                            if (ch == CH_PLUS || ch == CH_MINUS)
                            begin
                                int_negative = (ch == CH_MINUS);
                                text_phase   = SCAN_DIGITS;
                            end
                            else if (ch >= CH_DIGIT0 && ch <= CH_DIGIT9)
                            begin
                                add_decimal_digit(64'(ch - CH_DIGIT0));
                                text_phase = SCAN_DIGITS;
                            end
                            else
                                text_phase = SCAN_VALUE_DONE;
                        jkv_pkg::MODE_BOOLEAN:
                            match_true_char(ch);
                        default:
                            text_phase = SCAN_VALUE_DONE;
                    endcase
                end
            SCAN_STRING:
                if (ch == CH_NUL)
                    text_phase = SCAN_VALUE_DONE;
                else if (escape_next)
                begin
                    escape_next = 1'b0;
                    give        = 1'b1;
                end
                else if (ch == CH_QUOTE)
                    text_phase = SCAN_VALUE_DONE;
                else
                begin
                    escape_next = (ch == CH_BACKSLASH);
                    give        = 1'b1;
                end
            SCAN_DIGITS:
                if (ch >= CH_DIGIT0 && ch <= CH_DIGIT9)
                    add_decimal_digit(64'(ch - CH_DIGIT0));
                else
                    text_phase = SCAN_VALUE_DONE;
            SCAN_BOOL:
                match_true_char(ch);
            default:
                ;
        endcase
        return give;
    endfunction

    // Expected results of one accepted text request
    task automatic predict_text_request(logic [7:0] ch, logic eod);
        jkv_pkg::result_t res;
        bit               found;
        if (scan_json_byte(ch))
        begin
            res             = '0;
            res.result_kind = jkv_pkg::KIND_BYTE;
            res.value_byte  = ch;
            expected_results.push_back(res);
        end
        if (eod)
        begin
            found           = text_phase >= SCAN_BEFORE_VALUE && text_phase <= SCAN_VALUE_DONE;
            res             = '0;
            res.result_kind = jkv_pkg::KIND_FINAL;
            res.key_found   = found;
            if (found && extractor_cfg.value_mode == jkv_pkg::MODE_INTEGER)
            begin
                if (int_overflow)
                    res.integer_value = int_negative ? jkv_pkg::INT_NEG_LIMIT
                                                     : jkv_pkg::INT_POS_LIMIT;
                else
                    res.integer_value = int_negative ? 64'd0 - int_magnitude : int_magnitude;
            end
            res.boolean_value = found && extractor_cfg.value_mode == jkv_pkg::MODE_BOOLEAN &&
                                true_count == 4;
            expected_results.push_back(res);
            clear_scan();
        end
    endtask

    // Text driver: bursts of random length, random gaps, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_text.valid           <= 1'b0;
            in_text.text_byte       <= '0;
            in_text.end_of_document <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
            clear_scan();
        end
        else
        begin
            if (in_text.valid && in_text.ready)
            begin
                predict_text_request(in_text.text_byte, in_text.end_of_document);
                pending_text.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else if ($urandom_range(0, 3) == 0)
                begin
                    burst_left = 150;
                    gap_left   = 0;
                end
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = $urandom_range(0, 6);
                end
            end
            if (!in_text.valid || in_text.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_text.valid <= 1'b0;
                end
                else if (pending_text.size() > 0)
                begin
                    in_text.valid           <= 1'b1;
                    in_text.text_byte       <= pending_text[0].text_byte;
                    in_text.end_of_document <= pending_text[0].end_of_document;
                end
                else
                    in_text.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each result and stalls on a rotating pattern
    always @(posedge clk or negedge rst_n)
    begin
        jkv_pkg::result_t got;
        jkv_pkg::result_t want;
        if (!rst_n)
        begin
            out_result.ready <= 1'b0;
            stall_bits = '0;
            stall_pos  = '0;
        end
        else
        begin
            if (out_result.valid && out_result.ready)
            begin
                got.result_kind   = out_result.result_kind;
                got.value_byte    = out_result.value_byte;
                got.key_found     = out_result.key_found;
                got.integer_value = out_result.integer_value;
                got.boolean_value = out_result.boolean_value;
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected result: kind/byte/found/int/bool %0d/%02h/%0d/%0d/%0d",
                                 got.result_kind, got.value_byte, got.key_found,
                                 got.integer_value, got.boolean_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.result_kind !== want.result_kind ||
                        got.value_byte !== want.value_byte ||
                        got.key_found !== want.key_found ||
                        got.integer_value !== want.integer_value ||
                        got.boolean_value !== want.boolean_value)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("mismatch kind/byte/found/int/bool: exp %0d/%02h/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d",
                                     want.result_kind, want.value_byte, want.key_found,
                                     want.integer_value, want.boolean_value,
                                     got.result_kind, got.value_byte, got.key_found,
                                     got.integer_value, got.boolean_value);
                    end
                end
            end
            if (stall_pos == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_bits = '0;
                    1:       stall_bits = $urandom & $urandom;
                    2:       stall_bits = $urandom | $urandom;
                    default: stall_bits = $urandom;
                endcase
            end
            out_result.ready <= !stall_bits[stall_pos];
            stall_pos++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] rand_key_byte();
        logic [7:0] ch;
        do
            ch = 8'($urandom_range(1, 255));
        while (ch == CH_QUOTE);
        return ch;
    endfunction

    task automatic add_char(logic [7:0] ch);
        doc_text.push_back(ch);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++)
            doc_text.push_back(s[i]);
    endtask

    task automatic add_ws();
        int pick;
        repeat ($urandom_range(0, 2))
        begin
            pick = $urandom_range(0, 5);
            add_char((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick));
        end
    endtask

    // Queue the built document; its last byte carries end_of_document
    task automatic send_document();
        text_req_t req;
        foreach (doc_text[i])
        begin
            req.text_byte       = doc_text[i];
            req.end_of_document = (i == doc_text.size() - 1);
            pending_text.push_back(req);
        end
        text_bytes_queued += doc_text.size();
        doc_text.delete();
    endtask

    task automatic wait_until_idle();
        while (pending_text.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [jkv_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [jkv_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            jkv_pkg::REG_KEY_LOW:    extractor_cfg.key_low    = data;
            jkv_pkg::REG_KEY_HIGH:   extractor_cfg.key_high   = data;
            jkv_pkg::REG_KEY_LENGTH: extractor_cfg.key_length = data[jkv_pkg::KEY_POS_W-1:0];
            default:                 extractor_cfg.value_mode = data[1:0];
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic configure_extractor(logic [127:0] key_bits, logic [4:0] len, logic [1:0] mode);
        wait_until_idle();
        write_register(jkv_pkg::REG_KEY_LOW, key_bits[63:0]);
        write_register(jkv_pkg::REG_KEY_HIGH, key_bits[127:64]);
        write_register(jkv_pkg::REG_KEY_LENGTH, jkv_pkg::CFG_DATA_W'(len));
        write_register(jkv_pkg::REG_VALUE_MODE, jkv_pkg::CFG_DATA_W'(mode));
    endtask

    // One document: mostly members whose names hit or nearly hit the key,
    // sometimes pure noise, truncated, or with a NUL dropped in
    task automatic build_document();
        int         shape;
        int         nfields;
        int         n;
        int         cut;
        int         pick;
        logic [1:0] value_kind;
        doc_text.delete();
        shape = $urandom_range(0, 9);
        if (shape == 0)
        begin
            repeat ($urandom_range(1, 10))
                add_char(($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom));
        end
        else
        begin
            if ($urandom_range(0, 3) != 0)
                add_char(CH_OPEN_BRACE);
            nfields = $urandom_range(1, 3);
            for (int f = 0; f < nfields; f++)
            begin
                if (f != 0)
                    add_char(CH_COMMA);
                add_ws();
                add_char(CH_QUOTE);
                // member name: exact key, shortened, one byte off, too long, or unrelated
                pick = $urandom_range(0, 9);
                n = (extractor_cfg.key_length > jkv_pkg::MAX_KEY_LENGTH) ?
                    jkv_pkg::MAX_KEY_LENGTH : int'(extractor_cfg.key_length);
                if (pick < 8)
                begin
                    cut = (pick == 6 && n > 0) ? n - 1 : n;
                    for (int i = 0; i < cut; i++)
                        add_char((pick == 7 && i == n - 1) ? key_char(i) ^ 8'h01 : key_char(i));
                    if (extractor_cfg.key_length > jkv_pkg::MAX_KEY_LENGTH || pick == 5)
                        add_char(rand_key_byte());
                end
                else
                    repeat ($urandom_range(0, 4)) add_char(rand_key_byte());
                add_char(CH_QUOTE);
                add_ws();
                add_char(($urandom_range(0, 7) == 0) ? rand_key_byte() : CH_COLON);
                add_ws();
                // value, mostly of the configured kind
                value_kind = ($urandom_range(0, 3) == 0) ?
                             2'($urandom_range(0, 3)) : extractor_cfg.value_mode;
                case (value_kind)
                    jkv_pkg::MODE_STRING:
                    begin
                        add_char(CH_QUOTE);
                        repeat ($urandom_range(0, 6))
                        begin
                            pick = $urandom_range(0, 15);
                            if (pick == 0)
                                add_char(CH_NUL);
                            else if (pick < 4)
                            begin
                                add_char(CH_BACKSLASH);
                                add_char(8'($urandom));
                            end
                            else if (pick < 8)
                                add_char(8'($urandom_range(8'h61, 8'h7A)));
                            else
                                add_char(8'($urandom_range(1, 255)));
                        end
                        if ($urandom_range(0, 7) != 0)
                            add_char(CH_QUOTE);
                    end
                    jkv_pkg::MODE_INTEGER:
                    begin
                        pick = $urandom_range(0, 3);
                        if (pick == 1)
                            add_char(CH_PLUS);
                        else if (pick == 2)
                            add_char(CH_MINUS);
                        // values around both saturation limits, and short ones
                        case ($urandom_range(0, 6))
                            0:       add_str("9223372036854775807");
                            1:       add_str("9223372036854775808");
                            2:       add_str("9223372036854775809");
                            3:       add_str("18446744073709551616");
                            4:       repeat ($urandom_range(1, 22))
                                         add_char(CH_DIGIT0 + 8'($urandom_range(0, 9)));
                            default: repeat ($urandom_range(0, 3))
                                         add_char(CH_DIGIT0 + 8'($urandom_range(0, 9)));
                        endcase
                    end
                    jkv_pkg::MODE_BOOLEAN:
                        case ($urandom_range(0, 5))
                            0, 1:    add_str("true");
                            2:       add_str("tru");
                            3:       add_str("truex");
                            4:       add_str("false");
                            default: add_str("True");
                        endcase
                    default:
                        repeat ($urandom_range(1, 3)) add_char(8'($urandom));
                endcase
            end
            if ($urandom_range(0, 1) != 0)
                add_char(CH_CLOSE_BRACE);
            if (shape == 1)
            begin
                cut = $urandom_range(1, doc_text.size());
                while (doc_text.size() > cut)
                    void'(doc_text.pop_back());
            end
            if (shape == 2)
                doc_text[$urandom_range(0, doc_text.size() - 1)] = CH_NUL;
        end
    endtask

    // Stimulus: reset, a few directed documents, then random settings
    initial
    begin
        logic [127:0] key_bits;
        logic [4:0]   len;
        logic [1:0]   mode;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        extractor_cfg = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // string value with an escaped quote, then NUL-only and 0xFF-only documents
        configure_extractor(128'(DIRECTED_KEY), 5'd1, jkv_pkg::MODE_STRING);
        add_str("\"k\":\"a\\\"b\"");
        send_document();
        add_char(CH_NUL);
        send_document();
        add_char(8'hFF);
        send_document();
        configure_extractor(128'(DIRECTED_KEY), 5'd1, jkv_pkg::MODE_INTEGER);
        add_str("\"k\":-12");
        send_document();
        configure_extractor(128'(DIRECTED_KEY), 5'd1, jkv_pkg::MODE_BOOLEAN);
        add_str("\"k\":true");
        send_document();
        configure_extractor(128'(DIRECTED_KEY), 5'd1, MODE_KEY_ONLY);
        add_str("\"k\":1");
        send_document();

        // random part; the first settings hit the register extremes
        text_bytes_queued = 0;
        for (int phase = 0; text_bytes_queued < RANDOM_TEXT_BYTES; phase++)
        begin
            key_bits = {$urandom, $urandom, $urandom, $urandom};
            len      = 5'($urandom_range(1, 4));
            mode     = 2'($urandom_range(0, 3));
            case (phase)
                0:
                begin
                    key_bits = '1;
                    len      = 5'(jkv_pkg::MAX_KEY_LENGTH);
                    mode     = jkv_pkg::MODE_STRING;
                end
                1:
                begin
                    key_bits = '0;
                    len      = 5'd0;
                    mode     = jkv_pkg::MODE_INTEGER;
                end
                2:
                begin
                    len  = 5'd31;
                    mode = jkv_pkg::MODE_BOOLEAN;
                end
                3:
                begin
                    len  = 5'd17;
                    mode = MODE_KEY_ONLY;
                end
                4:
                    len = 5'($urandom_range(5, jkv_pkg::MAX_KEY_LENGTH));
                default:
                    if ($urandom_range(0, 4) == 0)
                        len = 5'($urandom_range(0, jkv_pkg::MAX_KEY_LENGTH));
            endcase
            // keep the used key bytes free of quote and NUL so matches are possible
            for (int i = 0; i < jkv_pkg::MAX_KEY_LENGTH; i++)
                if (i < len && (key_bits[8*i +: 8] == CH_QUOTE || key_bits[8*i +: 8] == CH_NUL))
                    key_bits[8*i +: 8] = rand_key_byte();
            configure_extractor(key_bits, len, mode);
            repeat (DOCS_PER_SETTING)
            begin
                build_document();
                send_document();
            end
        end

        wait_until_idle();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
